FILE: design/fp8cv_pkg.sv
package fp8cv_pkg;

    // Default small-format geometry: 1 sign, 3 exponent, 4 mantissa bits.
    localparam int SMALL_EXP_WIDTH_DEF  = 3;
    localparam int SMALL_MANT_WIDTH_DEF = 4;

    // Single-precision field layout.
    localparam int DATA_WIDTH     = 32;
    localparam int WIDE_EXP_WIDTH = 8;
    localparam int WIDE_MANT      = 23;
    localparam int WIDE_BIAS      = 127;
    localparam logic [WIDE_EXP_WIDTH-1:0] WIDE_EXP_MAX = 8'hFF;

    // Conversion direction carried in tuser.
    typedef enum logic
    {
        ACT_NARROW = 1'b0,
        ACT_WIDEN  = 1'b1
    } action_t;

    typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

FILE: design/fp32_fp8_format_converter_top.sv
// Channel   | Direction | tdata (low bit up)    | tuser (low bit up)       | Marks
// s_axis    | in        | source_bits [31:0]    | action [0] (1 = widen)   | none
// m_axis    | out       | result_bits [31:0]    | none                     | none
//
// One request is taken per cycle while s_axis_tready is high; its result passes through
// the input register and then the result register around the conversion logic.
// Reset (rst_n low, asynchronous) empties both stages.
// When m_axis stalls, the result register holds and the input register can
// still take one more request, so s_axis_tready drops only when both are full.
module fp32_fp8_format_converter_top #(
    parameter int SMALL_EXP_WIDTH  = fp8cv_pkg::SMALL_EXP_WIDTH_DEF,
    parameter int SMALL_MANT_WIDTH = fp8cv_pkg::SMALL_MANT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  fp8cv_pkg::word_t     s_axis_tdata,   // source_bits [31:0]
    input  fp8cv_pkg::action_t   s_axis_tuser,   // action [0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output fp8cv_pkg::word_t     m_axis_tdata    // result_bits [31:0]
);
    import fp8cv_pkg::*;

    localparam int SEW          = SMALL_EXP_WIDTH;
    localparam int SMW          = SMALL_MANT_WIDTH;
    localparam int SMALL_WIDTH  = 1 + SEW + SMW;
    localparam int SMALL_BIAS   = (1 << (SEW - 1)) - 1;
    localparam int SMALL_EMAX   = (1 << SEW) - 1;
    localparam int KW           = $clog2(SMW + 1);
    localparam logic [WIDE_EXP_WIDTH-1:0] OVF_EA   =
        WIDE_EXP_WIDTH'(WIDE_BIAS + SMALL_EMAX - SMALL_BIAS);
    localparam logic [WIDE_EXP_WIDTH-1:0] BOUND_EA =
        WIDE_EXP_WIDTH'(WIDE_BIAS - SMALL_BIAS);
    localparam logic [WIDE_EXP_WIDTH-1:0] SHIFT_LIMIT = WIDE_EXP_WIDTH'(WIDE_MANT);
    localparam logic [SEW-1:0] SMALL_EXP_ALL = {SEW{1'b1}};
    localparam logic [SMW-1:0] SMALL_MANT_ALL = {SMW{1'b1}};

    // Round a 23-bit fraction to the small mantissa, half up, carry dropped.
    function automatic logic [SMW-1:0] round_frac(input logic [WIDE_MANT-1:0] f);
        logic [SMW:0] sum;
        begin
            sum = {1'b0, f[WIDE_MANT-1 -: SMW]} + {{SMW{1'b0}}, f[WIDE_MANT-1-SMW]};
            if (sum[SMW])
                round_frac = f[WIDE_MANT-1 -: SMW];
            else
                round_frac = sum[SMW-1:0];
        end
    endfunction

    // Pipeline registers.
    logic      in_valid_reg;
    action_t   in_action_reg;
    word_t     in_bits_reg;
    logic      out_valid_reg;
    word_t     out_bits_reg;
    logic      advance;

    // Narrowing path signals.
    logic                      n_sign;
    logic [WIDE_EXP_WIDTH-1:0] n_ea;
    logic [WIDE_MANT-1:0]      n_mant;
    logic [WIDE_EXP_WIDTH-1:0] n_shift;
    logic [WIDE_EXP_WIDTH-1:0] n_exp_diff;
    logic [WIDE_MANT-1:0]      n_frac;
    logic [WIDE_MANT-1:0]      n_frac_sh;
    logic [SMW-1:0]            n_nan_mant;
    logic [SEW-1:0]            n_exp_out;
    logic [SMW-1:0]            n_mant_out;
    word_t                     narrow_bits;

    // Widening path signals.
    logic                      w_sign;
    logic [SEW-1:0]            w_ea;
    logic [SMW-1:0]            w_mant;
    logic [KW-1:0]             w_lz;
    logic                      w_found;
    logic [SMW-1:0]            w_norm_mant;
    logic [WIDE_EXP_WIDTH-1:0] w_exp_out;
    logic [WIDE_MANT-1:0]      w_mant_out;
    word_t                     widen_bits;
    word_t                     conv_bits;

    // Stage handshake: stage two moves when empty or drained downstream.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_bits_reg;

    // Narrowing: fp32 to the small format.
    always_comb
    begin
        n_sign     = in_bits_reg[DATA_WIDTH-1];
        n_ea       = in_bits_reg[DATA_WIDTH-2 -: WIDE_EXP_WIDTH];
        n_mant     = in_bits_reg[WIDE_MANT-1:0];
        n_shift    = BOUND_EA - n_ea - 8'd1;
        n_exp_diff = n_ea - BOUND_EA;
        n_frac     = {1'b1, n_mant[WIDE_MANT-1:1]};
        if (n_shift >= SHIFT_LIMIT)
            n_frac_sh = '0;
        else
            n_frac_sh = n_frac >> n_shift[4:0];
        n_nan_mant = round_frac(n_mant);
        if (n_nan_mant == '0)
            n_nan_mant = SMW'(1);
        if (n_ea == '0)
        begin
            n_exp_out  = '0;
            n_mant_out = '0;
        end
        else if (n_ea == WIDE_EXP_MAX)
        begin
            n_exp_out  = SMALL_EXP_ALL;
            n_mant_out = (n_mant == '0) ? '0 : n_nan_mant;
        end
        else if (n_ea >= OVF_EA)
        begin
            n_exp_out  = SMALL_EXP_ALL;
            n_mant_out = '0;
        end
        else if (n_ea == BOUND_EA)
        begin
            // Boundary exponent: least normal or largest denormal.
            if (n_mant[WIDE_MANT-1])
            begin
                n_exp_out  = SEW'(1);
                n_mant_out = '0;
            end
            else
            begin
                n_exp_out  = '0;
                n_mant_out = SMALL_MANT_ALL;
            end
        end
        else if (n_ea < BOUND_EA)
        begin
            n_exp_out  = '0;
            n_mant_out = round_frac(n_frac_sh);
        end
        else
        begin
            n_exp_out  = n_exp_diff[SEW-1:0];
            n_mant_out = round_frac(n_mant);
        end
        narrow_bits = '0;
        narrow_bits[SMALL_WIDTH-1:0] = {n_sign, n_exp_out, n_mant_out};
    end

    // Widening: small format to fp32; denormals are normalized.
    always_comb
    begin
        w_sign  = in_bits_reg[SEW+SMW];
        w_ea    = in_bits_reg[SEW+SMW-1:SMW];
        w_mant  = in_bits_reg[SMW-1:0];
        w_lz    = '0;
        w_found = 1'b0;
        for (int i = 0; i < SMW - 1; i++)
        begin
            if (!w_found)
            begin
                if (w_mant[SMW-1-i])
                    w_found = 1'b1;
                else
                    w_lz = w_lz + KW'(1);
            end
        end
        w_norm_mant = w_mant << w_lz;
        w_norm_mant = w_norm_mant << 1;
        if (w_ea == '0)
        begin
            if (w_mant == '0)
            begin
                w_exp_out  = '0;
                w_mant_out = '0;
            end
            else
            begin
                w_exp_out  = BOUND_EA - WIDE_EXP_WIDTH'(w_lz);
                w_mant_out = {w_norm_mant, {(WIDE_MANT-SMW){1'b0}}};
            end
        end
        else if (w_ea == SMALL_EXP_ALL)
        begin
            w_exp_out  = WIDE_EXP_MAX;
            w_mant_out = {w_mant, {(WIDE_MANT-SMW){1'b0}}};
        end
        else
        begin
            w_exp_out  = WIDE_EXP_WIDTH'(w_ea) + BOUND_EA;
            w_mant_out = {w_mant, {(WIDE_MANT-SMW){1'b0}}};
        end
        widen_bits = {w_sign, w_exp_out, w_mant_out};
    end

    assign conv_bits = (in_action_reg == ACT_WIDEN) ? widen_bits : narrow_bits;

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= s_axis_tuser;
            in_bits_reg   <= s_axis_tdata;
        end
    end

    // Result stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_bits_reg <= conv_bits;
    end

endmodule

FILE: design/fp8cv_checker.sv
module fp8cv_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input fp8cv_pkg::word_t     m_axis_tdata
);
    import fp8cv_pkg::*;

    // A result that starts showing comes from a request taken earlier, through both stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a matching request");

    // Requests are refused only when both stages hold items and output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while pipeline could move");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind fp32_fp8_format_converter_top fp8cv_checker u_fp8cv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/fp8_conv_checker.sv
`timescale 1ns / 100ps

module fp8_conv_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  fp8cv_pkg::word_t   s_axis_tdata,
    input  fp8cv_pkg::action_t s_axis_tuser,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  fp8cv_pkg::word_t   m_axis_tdata,
    output int                 fail_count,
    output int                 outstanding,
    output int                 results_checked
);
    import fp8cv_pkg::*;

    // Small-format geometry, taken from the package defaults the block is built with.
    localparam int EW       = SMALL_EXP_WIDTH_DEF;
    localparam int MW       = SMALL_MANT_WIDTH_DEF;
    localparam int FP8_BIAS = (1 << (EW - 1)) - 1;
    localparam int EXP_TOP  = (1 << EW) - 1;
    localparam int MANT_TOP = (1 << MW) - 1;
    localparam int REPORT_MAX = 10;

    typedef struct {
        action_t act;
        word_t   src;
        word_t   result;
    } conversion_t;

    conversion_t expected_q[$];

    function automatic word_t pack_fp8(input logic sgn, input logic [31:0] ex,
                                       input logic [31:0] mant);
        return (word_t'(sgn) << (EW + MW)) | ((ex & EXP_TOP) << MW) | (mant & MANT_TOP);
    endfunction

    function automatic word_t pack_fp32(input logic sgn, input logic [31:0] ex,
                                        input logic [31:0] mant);
        return {sgn, ex[WIDE_EXP_WIDTH-1:0], mant[WIDE_MANT-1:0]};
    endfunction

    // Rounds a 23-bit fraction half up; a carry out of the mantissa is dropped.
    function automatic logic [31:0] round_fp8_mant(input logic [WIDE_MANT-1:0] frac);
        logic [31:0] keep;
        logic [31:0] sum;
        keep = 32'(frac) >> (WIDE_MANT - MW);
        sum  = keep + ((32'(frac) >> (WIDE_MANT - 1 - MW)) & 32'd1);
        if (sum > MANT_TOP)
            sum = keep;
        return sum;
    endfunction

    function automatic word_t narrow_to_fp8(input word_t x);
        logic                  sgn;
        logic [7:0]            bexp;
        logic [WIDE_MANT-1:0]  frac;
        logic [WIDE_MANT-1:0]  den;
        logic [31:0]           mant;
        int                    unb;
        int                    sh;
        sgn  = x[31];
        bexp = x[30:23];
        frac = x[22:0];
        // Zero and fp32 denormals both flush to a signed zero.
        if (bexp == 8'd0)
            return pack_fp8(sgn, 0, 0);
        // Infinity stays infinity; a NaN never collapses into infinity.
        if (bexp == WIDE_EXP_MAX)
        begin
            if (frac == '0)
                return pack_fp8(sgn, EXP_TOP, 0);
            mant = round_fp8_mant(frac);
            if (mant == 0)
                mant = 1;
            return pack_fp8(sgn, EXP_TOP, mant);
        end
        unb = int'(bexp) - WIDE_BIAS;
        if (unb >= EXP_TOP - FP8_BIAS)
            return pack_fp8(sgn, EXP_TOP, 0);
        // Boundary exponent: least normal or largest denormal.
        if (unb == -FP8_BIAS)
            return frac[WIDE_MANT-1] ? pack_fp8(sgn, 1, 0) : pack_fp8(sgn, 0, MANT_TOP);
        // Deeper values shift 0.1f right into a denormal mantissa.
        if (unb < -FP8_BIAS)
        begin
            sh  = -FP8_BIAS - unb - 1;
            den = {1'b1, frac[WIDE_MANT-1:1]};
            den = (sh >= WIDE_MANT) ? '0 : (den >> sh);
            return pack_fp8(sgn, 0, round_fp8_mant(den));
        end
        return pack_fp8(sgn, unb + FP8_BIAS, round_fp8_mant(frac));
    endfunction

    function automatic word_t widen_to_fp32(input word_t x);
        logic        sgn;
        logic [31:0] bexp;
        logic [31:0] mant;
        int          lz;
        sgn  = x[EW+MW];
        bexp = (x >> MW) & EXP_TOP;
        mant = x & MANT_TOP;
        // Denormals are normalized against an exponent of one minus the bias.
        if (bexp == 0)
        begin
            if (mant == 0)
                return pack_fp32(sgn, 0, 0);
            lz = 0;
            while (lz < MW - 1 && mant[MW-1-lz] == 1'b0)
                lz++;
            return pack_fp32(sgn, WIDE_BIAS - FP8_BIAS - lz,
                             ((mant << (lz + 1)) & MANT_TOP) << (WIDE_MANT - MW));
        end
        if (bexp == EXP_TOP)
            return pack_fp32(sgn, WIDE_EXP_MAX, mant << (WIDE_MANT - MW));
        return pack_fp32(sgn, bexp - FP8_BIAS + WIDE_BIAS, mant << (WIDE_MANT - MW));
    endfunction

    // Compare each result with the oldest pending request, then log new requests.
    always @(posedge clk or negedge rst_n)
    begin
        conversion_t pending;
        conversion_t incoming;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_count      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: mismatch: unexpected result %h", $realtime,
                                 m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    pending = expected_q.pop_front();
                    results_checked <= results_checked + 1;
                    if (m_axis_tdata !== pending.result)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("%0t: mismatch: %s of %h expected %h, got %h",
                                     $realtime, pending.act.name(), pending.src,
                                     pending.result, m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                incoming.act    = s_axis_tuser;
                incoming.src    = s_axis_tdata;
                incoming.result = (s_axis_tuser == ACT_WIDEN) ? widen_to_fp32(s_axis_tdata)
                                                              : narrow_to_fp8(s_axis_tdata);
                expected_q.push_back(incoming);
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fp8cv_pkg::*;

    localparam int RANDOM_ITEMS = 925;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 6;

    logic    clk;
    logic    rst_n;
    logic    s_axis_tvalid;
    logic    s_axis_tready;
    word_t   s_axis_tdata;
    action_t s_axis_tuser;
    logic    m_axis_tvalid;
    logic    m_axis_tready;
    word_t   m_axis_tdata;

    int fail_count;
    int outstanding;
    int results_checked;

    bit gaps_on;
    bit hold_request;
    int hold_left;
    int idle_cycles;
    int narrow_sent;
    int widen_sent;

    fp32_fp8_format_converter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fp8_conv_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offers one request, with random idle cycles ahead of it; returns at a falling edge.
    task automatic send_request(input action_t act, input word_t src);
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= src;
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_WIDEN)
            widen_sent++;
        else
            narrow_sent++;
        @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 11);
        end
    end

    // Stop the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without progress.", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int      kind;
        logic    sgn;
        logic [7:0]  bexp;
        logic [22:0] frac;
        word_t   src;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_NARROW;
        gaps_on       = 1'b1;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        narrow_sent   = 0;
        widen_sent    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Narrowing corners: zeros, denormal input, infinities, NaNs, overflow,
        // carry dropped at the top, half-up rounding, boundary exponent, deep denormals.
        send_request(ACT_NARROW, 32'h0000_0000);
        send_request(ACT_NARROW, 32'h8000_0000);
        send_request(ACT_NARROW, 32'h0000_0001);
        send_request(ACT_NARROW, 32'h7F80_0000);
        send_request(ACT_NARROW, 32'hFF80_0000);
        send_request(ACT_NARROW, 32'h7F80_0001);
        send_request(ACT_NARROW, 32'h7FC0_0000);
        send_request(ACT_NARROW, 32'hFFFF_FFFF);
        send_request(ACT_NARROW, 32'h4180_0000);
        send_request(ACT_NARROW, 32'h417F_FFFF);
        send_request(ACT_NARROW, 32'h7F7F_FFFF);
        send_request(ACT_NARROW, 32'h3F84_0000);
        send_request(ACT_NARROW, 32'hBE40_0000);
        send_request(ACT_NARROW, 32'h3E00_0000);
        send_request(ACT_NARROW, 32'h3D80_0000);
        send_request(ACT_NARROW, 32'h3200_0000);

        // Widening corners: zeros, denormals, infinities, NaN, normal, upper bits set.
        send_request(ACT_WIDEN, 32'h0000_0000);
        send_request(ACT_WIDEN, 32'h0000_0080);
        send_request(ACT_WIDEN, 32'h0000_0001);
        send_request(ACT_WIDEN, 32'h0000_008F);
        send_request(ACT_WIDEN, 32'h0000_0070);
        send_request(ACT_WIDEN, 32'h0000_00F0);
        send_request(ACT_WIDEN, 32'h0000_007F);
        send_request(ACT_WIDEN, 32'hFFFF_FF3C);

        // The result side now holds off while requests keep coming.
        hold_request = 1'b1;

        // Random mix, weighted toward exponents near the small format's range.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gaps_on = !(i >= 300 && i < 480);
            kind    = $urandom_range(0, 9);
            sgn     = 1'($urandom_range(0, 1));
            frac    = 23'($urandom());
            if (kind <= 2)
                send_request(ACT_WIDEN, $urandom());
            else if (kind <= 5)
            begin
                bexp = 8'($urandom_range(WIDE_BIAS - 31, WIDE_BIAS + 5));
                send_request(ACT_NARROW, {sgn, bexp, frac});
            end
            else if (kind == 6)
            begin
                // Zero, denormal, infinity and NaN inputs, often with a small fraction.
                bexp = $urandom_range(0, 1) ? WIDE_EXP_MAX : 8'h00;
                if ($urandom_range(0, 2) == 0)
                    frac = 23'($urandom_range(0, 23'h7_FFFF));
                if ($urandom_range(0, 7) == 0)
                    frac = '0;
                send_request(ACT_NARROW, {sgn, bexp, frac});
            end
            else
            begin
                src = $urandom();
                send_request(ACT_NARROW, src);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a few more cycles for any stray result.
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d requests (%0d narrowing, %0d widening) incl. zeros, denormals,",
                 narrow_sent + widen_sent, narrow_sent, widen_sent);
        $display("infinities, NaNs, rounding edges and a long output stall; %0d results checked.",
                 results_checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
